[src/ttc_pkg.sv]
// Shared constants, codes and types of the tile texture cache.
package ttc_pkg;

    localparam int TABLE_CAPACITY = 256;
    localparam int IDX_W          = $clog2(TABLE_CAPACITY);
    localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
    localparam int POOL_DEPTH     = 32;
    localparam int POOL_IDX_W     = $clog2(POOL_DEPTH);
    localparam int POOL_CNT_W     = $clog2(POOL_DEPTH + 1);
    localparam int HANDLE_BITS    = 16;
    localparam int KEY_W          = 61;
    localparam int WORD_W         = 64;
    localparam int FRAME_W        = 32;
    localparam int RES_W          = 12;
    localparam int SQ_W           = 23;
    localparam int PROD_W         = 30;
    localparam int LIM_W          = 8;
    localparam int EVICT_W        = 9;
    localparam int CMD_W          = 4;
    localparam int CFG_IDX_W      = 2;

    localparam logic [RES_W-1:0]  RES_MIN        = RES_W'(128);
    localparam logic [RES_W-1:0]  RES_MAX        = RES_W'(2048);
    localparam logic [RES_W-1:0]  RES_RESET      = RES_W'(1024);
    localparam logic [LIM_W-1:0]  LIMIT_MIN      = LIM_W'(24);
    localparam logic [LIM_W-1:0]  LIMIT_MAX      = LIM_W'(160);
    localparam logic [PROD_W-1:0] BUDGET_QUARTER = PROD_W'(96 * 1024 * 1024 / 4);

    localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_FIND_BAKED  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_BAKED  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_SEEDED = 4'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_BEGIN_FRAME = 4'd5;
    localparam logic [CMD_W-1:0] CMD_END_FRAME   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SET_SIG     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FLUSH       = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_EN  = 2'd1;

    typedef enum logic [1:0] {
        WALK_LOOKUP,
        WALK_EVICT,
        WALK_FRAME,
        WALK_SIGN
    } walk_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [HANDLE_BITS-1:0] handle;
        logic [WORD_W-1:0]      fingerprint;
        logic [WORD_W-1:0]      layer_mask;
        logic                   baked;
        logic                   seeded;
        logic                   stale;
        logic                   used;
        logic [FRAME_W-1:0]     last_frame;
    } entry_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic                   needs_bake;
        logic                   has_content;
        logic                   found;
        logic                   is_baked;
        logic                   is_stale;
        logic [WORD_W-1:0]      layer_mask;
        logic [EVICT_W-1:0]     evicted;
        logic                   table_full;
    } result_t;

    typedef struct packed {
        logic             capture;
        logic             walk_rd;
        logic [IDX_W-1:0] walk_idx;
        walk_mode_t       walk_mode;
        logic             apply;
        logic             create;
        logic             full_mark;
        logic             evict;
        logic             frame_inc;
        logic             sig_store;
        logic             flush;
        logic             lim_sq;
        logic             lim_init;
        logic             lim_step;
        logic             publish;
    } ctl_t;

    typedef struct packed {
        logic hit;
        logic free_found;
        logic best_found;
        logic over_limit;
        logic lim_done;
        logic sig_diff;
    } stat_t;

endpackage

[src/ttc_ctrl.sv]
// Command sequencer of the tile texture cache.
module ttc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ttc_pkg::CMD_W-1:0]   cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ttc_pkg::ctl_t               ctl,
    input  ttc_pkg::stat_t              st
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIG_CHK,
        S_WALK,
        S_WALK_END,
        S_POST,
        S_APPLY,
        S_LIM_INIT,
        S_LIM_STEP,
        S_EV_CHK,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    ttc_pkg::walk_mode_t           mode_reg, mode_next;
    logic [ttc_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ttc_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        ctl.walk_idx   = idx_reg;
        ctl.walk_mode  = mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    cmd_next    = cmd;
                    idx_next    = '0;
                    if (cmd inside {[ttc_pkg::CMD_ACQUIRE:ttc_pkg::CMD_QUERY]})
                    begin
                        mode_next  = ttc_pkg::WALK_LOOKUP;
                        state_next = S_WALK;
                    end
                    else if (cmd == ttc_pkg::CMD_BEGIN_FRAME)
                    begin
                        ctl.frame_inc = 1'b1;
                        mode_next     = ttc_pkg::WALK_FRAME;
                        state_next    = S_WALK;
                    end
                    else if (cmd == ttc_pkg::CMD_END_FRAME)
                    begin
                        ctl.lim_sq = 1'b1;
                        state_next = S_LIM_INIT;
                    end
                    else if (cmd == ttc_pkg::CMD_SET_SIG)
                    begin
                        state_next = S_SIG_CHK;
                    end
                    else if (cmd == ttc_pkg::CMD_FLUSH)
                    begin
                        ctl.flush  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SIG_CHK:
            begin
                if (st.sig_diff)
                begin
                    ctl.sig_store = 1'b1;
                    mode_next     = ttc_pkg::WALK_SIGN;
                    idx_next      = '0;
                    state_next    = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                ctl.walk_rd = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == ttc_pkg::IDX_W'(ttc_pkg::TABLE_CAPACITY - 1))
                begin
                    state_next = S_WALK_END;
                end
            end
            S_WALK_END:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                case (mode_reg)
                    ttc_pkg::WALK_LOOKUP:
                    begin
                        if (st.hit)
                        begin
                            state_next = S_APPLY;
                        end
                        else if (cmd_reg == ttc_pkg::CMD_ACQUIRE)
                        begin
                            if (st.free_found)
                            begin
                                ctl.create = 1'b1;
                            end
                            else
                            begin
                                ctl.full_mark = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ttc_pkg::WALK_EVICT:
                    begin
                        if (st.best_found)
                        begin
                            ctl.evict  = 1'b1;
                            state_next = S_EV_CHK;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_APPLY:
            begin
                ctl.apply  = 1'b1;
                state_next = S_DONE;
            end
            S_LIM_INIT:
            begin
                ctl.lim_init = 1'b1;
                state_next   = S_LIM_STEP;
            end
            S_LIM_STEP:
            begin
                if (st.lim_done)
                begin
                    state_next = S_EV_CHK;
                end
                else
                begin
                    ctl.lim_step = 1'b1;
                end
            end
            S_EV_CHK:
            begin
                if (st.over_limit)
                begin
                    mode_next  = ttc_pkg::WALK_EVICT;
                    idx_next   = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= ttc_pkg::WALK_LOOKUP;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/ttc_dpath.sv]
// Entry table, handle pool, limit unit and result registers of the tile texture cache.
module ttc_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttc_pkg::ctl_t                   ctl,
    output ttc_pkg::stat_t                  st,
    input  logic [ttc_pkg::CMD_W-1:0]       cmd,
    input  logic [7:0]                      stack_id,
    input  logic [4:0]                      tile_zoom,
    input  logic [23:0]                     tile_x,
    input  logic [23:0]                     tile_y,
    input  logic [ttc_pkg::WORD_W-1:0]      fingerprint,
    input  logic [ttc_pkg::WORD_W-1:0]      layer_mask_in,
    input  logic [ttc_pkg::WORD_W-1:0]      signature,
    input  logic                            cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttc_pkg::RES_W-1:0]       cfg_data,
    output ttc_pkg::result_t                result
);

    ttc_pkg::entry_t entry_mem [ttc_pkg::TABLE_CAPACITY];
    ttc_pkg::entry_t rd_data_reg;
    logic [ttc_pkg::HANDLE_BITS-1:0] pool_stack_reg [ttc_pkg::POOL_DEPTH];

    logic [ttc_pkg::TABLE_CAPACITY-1:0]  valid_reg;
    logic [ttc_pkg::CNT_W-1:0]           count_reg;
    logic [ttc_pkg::POOL_CNT_W-1:0]      pool_cnt_reg;
    logic [ttc_pkg::HANDLE_BITS-1:0]     fresh_reg;
    logic [ttc_pkg::FRAME_W-1:0]         frame_reg;
    logic [ttc_pkg::WORD_W-1:0]          sig_reg;
    logic [ttc_pkg::RES_W-1:0]           resolution_reg;
    logic                                budget_en_reg;

    logic [ttc_pkg::CMD_W-1:0]           item_cmd_reg;
    logic [ttc_pkg::KEY_W-1:0]           key_reg;
    logic [ttc_pkg::WORD_W-1:0]          fp_reg;
    logic [ttc_pkg::WORD_W-1:0]          mask_reg;
    logic [ttc_pkg::WORD_W-1:0]          sig_item_reg;

    logic                                probe_live_reg;
    logic [ttc_pkg::IDX_W-1:0]           probe_idx_reg;
    logic                                hit_reg;
    logic [ttc_pkg::IDX_W-1:0]           slot_reg;
    logic                                free_found_reg;
    logic [ttc_pkg::IDX_W-1:0]           free_idx_reg;
    logic                                best_found_reg;
    logic [ttc_pkg::IDX_W-1:0]           best_idx_reg;
    logic [ttc_pkg::FRAME_W-1:0]         best_last_reg;
    logic [ttc_pkg::KEY_W-1:0]           best_key_reg;
    logic [ttc_pkg::HANDLE_BITS-1:0]     best_handle_reg;

    logic [ttc_pkg::SQ_W-1:0]            sq_reg;
    logic [ttc_pkg::PROD_W-1:0]          prod_reg;
    logic [ttc_pkg::LIM_W-1:0]           n_reg;

    ttc_pkg::result_t                    res_reg, res_next;
    ttc_pkg::result_t                    out_reg;

    ttc_pkg::entry_t                     probe_e;
    ttc_pkg::entry_t                     wr_data;
    logic                                wr_en;
    logic [ttc_pkg::IDX_W-1:0]           wr_addr;
    logic [ttc_pkg::IDX_W-1:0]           rd_addr;
    logic                                probe_v;
    logic                                older;
    logic                                hit_cand;
    logic                                free_cand;
    logic                                best_cand;
    logic                                walk_first;
    logic [ttc_pkg::HANDLE_BITS-1:0]     take_handle;
    logic [ttc_pkg::HANDLE_BITS-1:0]     fresh_adv;
    logic [ttc_pkg::RES_W-1:0]           res_clamped;
    logic                                res_change;
    logic                                clear_all;
    logic [2*ttc_pkg::RES_W-1:0]         sq_full;
    logic [ttc_pkg::LIM_W-1:0]           limit;

    always_comb
    begin
        res_clamped = cfg_data;
        if (cfg_data < ttc_pkg::RES_MIN)
        begin
            res_clamped = ttc_pkg::RES_MIN;
        end
        else if (cfg_data > ttc_pkg::RES_MAX)
        begin
            res_clamped = ttc_pkg::RES_MAX;
        end
    end

    assign res_change = cfg_we && (cfg_index == ttc_pkg::CFG_RESOLUTION) &&
                        (res_clamped != resolution_reg);
    assign clear_all  = ctl.flush || res_change;
    assign walk_first = ctl.walk_rd && (ctl.walk_idx == '0);
    assign rd_addr    = ctl.walk_rd ? ctl.walk_idx : slot_reg;
    assign sq_full    = {ttc_pkg::RES_W'(0), resolution_reg} *
                        {ttc_pkg::RES_W'(0), resolution_reg};
    assign limit      = budget_en_reg ? n_reg : ttc_pkg::LIMIT_MAX;

    always_comb
    begin
        probe_e   = rd_data_reg;
        probe_v   = valid_reg[probe_idx_reg];
        older     = (probe_e.last_frame < best_last_reg) ||
                    ((probe_e.last_frame == best_last_reg) && (probe_e.key < best_key_reg));
        hit_cand  = probe_live_reg && (ctl.walk_mode == ttc_pkg::WALK_LOOKUP) &&
                    probe_v && (probe_e.key == key_reg) && !hit_reg;
        free_cand = probe_live_reg && (ctl.walk_mode == ttc_pkg::WALK_LOOKUP) &&
                    !probe_v && !free_found_reg;
        best_cand = probe_live_reg && (ctl.walk_mode == ttc_pkg::WALK_EVICT) &&
                    probe_v && !probe_e.used && (!best_found_reg || older);

        if (pool_cnt_reg != '0)
        begin
            take_handle = pool_stack_reg[ttc_pkg::POOL_IDX_W'(pool_cnt_reg - 1'b1)];
        end
        else
        begin
            take_handle = fresh_reg;
        end
        fresh_adv = fresh_reg + 1'b1;
        if (fresh_adv == '0)
        begin
            fresh_adv = ttc_pkg::HANDLE_BITS'(1);
        end

        wr_en    = 1'b0;
        wr_addr  = probe_idx_reg;
        wr_data  = probe_e;
        res_next = res_reg;

        if (probe_live_reg && (ctl.walk_mode == ttc_pkg::WALK_FRAME))
        begin
            wr_en        = 1'b1;
            wr_data.used = 1'b0;
        end
        if (probe_live_reg && (ctl.walk_mode == ttc_pkg::WALK_SIGN))
        begin
            wr_en          = 1'b1;
            wr_data.stale  = probe_e.baked || probe_e.seeded;
            wr_data.seeded = 1'b0;
        end

        if (ctl.apply)
        begin
            wr_addr        = slot_reg;
            res_next.found = 1'b1;
            case (item_cmd_reg)
                ttc_pkg::CMD_ACQUIRE:
                begin
                    wr_en                = 1'b1;
                    wr_data.used         = 1'b1;
                    wr_data.last_frame   = frame_reg;
                    res_next.handle      = probe_e.handle;
                    res_next.needs_bake  = !probe_e.baked || probe_e.stale ||
                                           (probe_e.fingerprint != fp_reg);
                    res_next.has_content = probe_e.baked || probe_e.seeded;
                end
                ttc_pkg::CMD_FIND_BAKED:
                begin
                    if (probe_e.baked && !probe_e.stale)
                    begin
                        wr_en              = 1'b1;
                        wr_data.used       = 1'b1;
                        wr_data.last_frame = frame_reg;
                        res_next.handle    = probe_e.handle;
                    end
                end
                ttc_pkg::CMD_MARK_BAKED:
                begin
                    wr_en               = 1'b1;
                    wr_data.fingerprint = fp_reg;
                    wr_data.layer_mask  = mask_reg;
                    wr_data.baked       = 1'b1;
                    wr_data.seeded      = 1'b0;
                    wr_data.stale       = 1'b0;
                end
                ttc_pkg::CMD_MARK_SEEDED:
                begin
                    wr_en          = 1'b1;
                    wr_data.seeded = 1'b1;
                end
                ttc_pkg::CMD_QUERY:
                begin
                    res_next.is_baked   = probe_e.baked;
                    res_next.is_stale   = probe_e.stale;
                    res_next.layer_mask = probe_e.baked ? probe_e.layer_mask : '0;
                end
                default:
                begin
                    res_next.found = 1'b0;
                end
            endcase
        end

        if (ctl.create)
        begin
            wr_en               = 1'b1;
            wr_addr             = free_idx_reg;
            wr_data.key         = key_reg;
            wr_data.handle      = take_handle;
            wr_data.fingerprint = '0;
            wr_data.layer_mask  = '0;
            wr_data.baked       = 1'b0;
            wr_data.seeded      = 1'b0;
            wr_data.stale       = 1'b0;
            wr_data.used        = 1'b1;
            wr_data.last_frame  = frame_reg;
            res_next.handle     = take_handle;
            res_next.needs_bake = 1'b1;
        end

        if (ctl.full_mark)
        begin
            res_next.table_full = 1'b1;
        end
        if (ctl.evict)
        begin
            res_next.evicted = res_reg.evicted + 1'b1;
        end
        if (ctl.capture)
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.evict && (pool_cnt_reg < ttc_pkg::POOL_CNT_W'(ttc_pkg::POOL_DEPTH)))
        begin
            pool_stack_reg[ttc_pkg::POOL_IDX_W'(pool_cnt_reg)] <= best_handle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            pool_cnt_reg   <= '0;
            fresh_reg      <= ttc_pkg::HANDLE_BITS'(1);
            frame_reg      <= '0;
            sig_reg        <= '0;
            resolution_reg <= ttc_pkg::RES_RESET;
            budget_en_reg  <= 1'b1;
            probe_live_reg <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg    <= '0;
                count_reg    <= '0;
                pool_cnt_reg <= '0;
            end
            else if (ctl.create)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                count_reg               <= count_reg + 1'b1;
                if (pool_cnt_reg != '0)
                begin
                    pool_cnt_reg <= pool_cnt_reg - 1'b1;
                end
                else
                begin
                    fresh_reg <= fresh_adv;
                end
            end
            else if (ctl.evict)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                count_reg               <= count_reg - 1'b1;
                if (pool_cnt_reg < ttc_pkg::POOL_CNT_W'(ttc_pkg::POOL_DEPTH))
                begin
                    pool_cnt_reg <= pool_cnt_reg + 1'b1;
                end
            end
            if (res_change)
            begin
                resolution_reg <= res_clamped;
            end
            if (cfg_we && (cfg_index == ttc_pkg::CFG_BUDGET_EN))
            begin
                budget_en_reg <= cfg_data[0];
            end
            if (ctl.frame_inc)
            begin
                frame_reg <= frame_reg + 1'b1;
            end
            if (ctl.sig_store)
            begin
                sig_reg <= sig_item_reg;
            end
            probe_live_reg <= ctl.walk_rd;
            if (walk_first)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (hit_cand)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_cand)
                begin
                    free_found_reg <= 1'b1;
                end
                if (best_cand)
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_cmd_reg <= cmd;
            key_reg      <= {stack_id, tile_zoom, tile_x, tile_y};
            fp_reg       <= fingerprint;
            mask_reg     <= layer_mask_in;
            sig_item_reg <= signature;
        end
        probe_idx_reg <= ctl.walk_idx;
        if (hit_cand)
        begin
            slot_reg <= probe_idx_reg;
        end
        if (free_cand)
        begin
            free_idx_reg <= probe_idx_reg;
        end
        if (best_cand)
        begin
            best_idx_reg    <= probe_idx_reg;
            best_last_reg   <= probe_e.last_frame;
            best_key_reg    <= probe_e.key;
            best_handle_reg <= probe_e.handle;
        end
        if (ctl.lim_sq)
        begin
            sq_reg <= sq_full[ttc_pkg::SQ_W-1:0];
        end
        if (ctl.lim_init)
        begin
            prod_reg <= ttc_pkg::PROD_W'(sq_reg) * ttc_pkg::PROD_W'(ttc_pkg::LIMIT_MAX);
            n_reg    <= ttc_pkg::LIMIT_MAX;
        end
        else if (ctl.lim_step)
        begin
            prod_reg <= prod_reg - ttc_pkg::PROD_W'(sq_reg);
            n_reg    <= n_reg - 1'b1;
        end
        res_reg <= res_next;
        if (ctl.publish)
        begin
            out_reg <= res_next;
        end
    end

    assign st.hit        = hit_reg;
    assign st.free_found = free_found_reg;
    assign st.best_found = best_found_reg;
    assign st.over_limit = count_reg > ttc_pkg::CNT_W'(limit);
    assign st.lim_done   = !budget_en_reg || (n_reg == ttc_pkg::LIMIT_MIN) ||
                           (prod_reg <= ttc_pkg::BUDGET_QUARTER);
    assign st.sig_diff   = sig_item_reg != sig_reg;
    assign result        = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.create |-> free_found_reg && !valid_reg[free_idx_reg])
        else $error("create targets an occupied slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.evict |-> best_found_reg && valid_reg[best_idx_reg])
        else $error("evict targets an empty slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.apply |-> hit_reg && valid_reg[slot_reg])
        else $error("update without a matching entry");

endmodule

[src/tile_texture_cache_lru_unit.sv]
// Top level of the tile texture cache with least-recently-used eviction.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  request   | in_valid / in_ready    | cmd, stack_id, tile_zoom, tile_x, tile_y,
//            |                        | fingerprint, layer_mask_in, signature
//  result    | out_valid / out_ready  | handle, needs_bake, has_content, found,
//            |                        | is_baked, is_stale, layer_mask_out,
//            |                        | evicted, table_full
//  config    | cfg_we                 | cfg_index, cfg_data
//
// Lookup commands, begin_frame and a set_signature that changes the signature walk all
// 256 entries through the single-read entry memory. Flush and unknown codes skip the walk.
// End_frame runs the limit search, then one full walk per eviction while over the limit.
// Reset empties the table at once through per-entry valid bits; no clearing pass.
// One request is in flight at a time; a finished result waits in the output register.
module tile_texture_cache_lru_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ttc_pkg::CMD_W-1:0]           cmd,
    input  logic [7:0]                          stack_id,
    input  logic [4:0]                          tile_zoom,
    input  logic [23:0]                         tile_x,
    input  logic [23:0]                         tile_y,
    input  logic [ttc_pkg::WORD_W-1:0]          fingerprint,
    input  logic [ttc_pkg::WORD_W-1:0]          layer_mask_in,
    input  logic [ttc_pkg::WORD_W-1:0]          signature,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ttc_pkg::HANDLE_BITS-1:0]     handle,
    output logic                                needs_bake,
    output logic                                has_content,
    output logic                                found,
    output logic                                is_baked,
    output logic                                is_stale,
    output logic [ttc_pkg::WORD_W-1:0]          layer_mask_out,
    output logic [ttc_pkg::EVICT_W-1:0]         evicted,
    output logic                                table_full,
    input  logic                                cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttc_pkg::RES_W-1:0]           cfg_data
);

    ttc_pkg::ctl_t    ctl;
    ttc_pkg::stat_t   st;
    ttc_pkg::result_t result;

    ttc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .st        (st)
    );

    ttc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cmd           (cmd),
        .stack_id      (stack_id),
        .tile_zoom     (tile_zoom),
        .tile_x        (tile_x),
        .tile_y        (tile_y),
        .fingerprint   (fingerprint),
        .layer_mask_in (layer_mask_in),
        .signature     (signature),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result)
    );

    assign handle         = result.handle;
    assign needs_bake     = result.needs_bake;
    assign has_content    = result.has_content;
    assign found          = result.found;
    assign is_baked       = result.is_baked;
    assign is_stale       = result.is_stale;
    assign layer_mask_out = result.layer_mask;
    assign evicted        = result.evicted;
    assign table_full     = result.table_full;

endmodule
